@@ design/lphs_pkg.sv @@
// Shared types, codes and defaults for the linear probing hash set.
`default_nettype none

package lphs_pkg;

    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 10;
    localparam int FILL_W      = 11;

    localparam int DEFAULT_TABLE_DEPTH = 1024;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [FILL_W-1:0]   t_fill;

    localparam t_fill MAX_FILL_RESET = 11'd768;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_FIND   = 2'd2;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_PRESENT   = 3'd1;
    localparam t_status ST_REMOVED   = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FOUND     = 3'd4;
    localparam t_status ST_FULL      = 3'd5;

    typedef struct packed {
        logic used;
        logic deleted;
    } t_flags;

endpackage

`default_nettype wire

@@ design/lphs_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with a registered read port.
`default_nettype none

module lphs_ram
    import lphs_pkg::*;
#(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/lphs_home.sv @@
// Home slot unit: signed key modulo the table depth, four bits per cycle (non-power-of-two).
`default_nettype none

module lphs_home
    import lphs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire t_key                           i_key,
    output logic                                o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_home
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int REM_W     = IDX_W + 1;
    localparam int STEP_BITS = 4;
    localparam int STEPS     = KEY_W / STEP_BITS;
    localparam int CNT_W     = $clog2(STEPS);
    localparam bit IS_POW2   = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [IDX_W-1:0] WRAP = IDX_W'((64'd1 << KEY_W) % 64'(TABLE_DEPTH));
    localparam logic [REM_W-1:0] DEPTH_R = REM_W'(TABLE_DEPTH);

    logic             r_busy;
    logic             r_fix;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_key             r_bits;
    logic [IDX_W-1:0] r_rem;
    logic             r_neg;
    logic [IDX_W-1:0] r_home;

    logic [IDX_W-1:0] n_step_rem;
    logic [IDX_W-1:0] n_fix_home;

    always_comb begin
        logic [REM_W-1:0] acc;
        acc = REM_W'(r_rem);
        for (int i = 0; i < STEP_BITS; i++) begin
            acc = {acc[REM_W-2:0], r_bits[KEY_W-1-i]};
            if (acc >= DEPTH_R) begin
                acc = acc - DEPTH_R;
            end
        end
        n_step_rem = acc[IDX_W-1:0];
    end

    always_comb begin
        logic [REM_W-1:0] val;
        val = REM_W'(r_rem);
        if (r_neg) begin
            val = val - REM_W'(WRAP);
        end
        if (val[REM_W-1]) begin
            val = val + DEPTH_R;
        end
        n_fix_home = val[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_cnt  <= '0;
            r_fix  <= 1'b0;
            r_busy <= !IS_POW2;
            r_done <= IS_POW2;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end
        end else if (r_fix) begin
            r_fix  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bits <= i_key;
            r_rem  <= '0;
            r_neg  <= i_key[KEY_W-1];
            r_home <= i_key[IDX_W-1:0];
        end else if (r_busy) begin
            r_bits <= r_bits << STEP_BITS;
            r_rem  <= n_step_rem;
        end else if (r_fix) begin
            r_home <= n_fix_home;
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

`default_nettype wire

@@ design/linear_probe_hash_set.sv @@
// Top level of the linear probing hash set: request sequencer, slot stores and fill count.
//
// Requests arrive on the input channel (i_in_valid, o_in_ready) as an operation and a
// signed key; each request gives exactly one result beat on the output channel
// (o_out_valid, i_out_ready) carrying a status and a slot index. The fill limit is
// written on the configuration channel (i_cfg_valid, o_cfg_ready), which is always ready.
// One request is worked on at a time. The home slot is the low key bits when TABLE_DEPTH is a
// power of two and otherwise a shift-subtract remainder, four key bits per cycle, followed
// by a sign fix-up step. The slot memories are then read one slot per cycle until the
// request finishes; the next request can be accepted in the same cycle as that result shows.
// After reset the block sweeps the flag memory to clear every slot, one slot per cycle,
// and holds o_in_ready low meanwhile; configuration writes are taken during the sweep.
// The result sits in an output register, so a new request is accepted while it waits;
// a request that is ready to finish while the receiver stalls holds its memory update
// until the output register can take its result.
`default_nettype none

module linear_probe_hash_set
    import lphs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire t_op            i_operation,
    input  wire logic signed [KEY_W-1:0] i_key,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output t_status             o_status,
    output logic [SLOT_W-1:0]   o_slot,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire t_fill          i_cfg_max_fill
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_HOME  = 2'd2;
    localparam logic [1:0] S_PROBE = 2'd3;

    logic [1:0]       r_state, n_state;
    t_op              r_op, n_op;
    t_key             r_key, n_key;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_probe, n_probe;
    t_fill            r_used_count, n_used_count;
    t_fill            r_max_fill;
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [IDX_W-1:0] r_slot, n_slot;

    logic             home_start;
    logic             home_done;
    logic [IDX_W-1:0] home_idx;

    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic             flag_we;
    logic [IDX_W-1:0] flag_waddr;
    t_flags           flag_wdata;
    t_flags           flag_rdata;
    logic             key_we;
    t_key             key_rdata;

    logic             out_free;
    logic             key_match;
    logic [IDX_W-1:0] next_idx;

    lphs_home #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_home (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(home_start),
        .i_key  (t_key'(i_key)),
        .o_done (home_done),
        .o_home (home_idx)
    );

    lphs_ram #(
        .WIDTH($bits(t_flags)),
        .DEPTH(TABLE_DEPTH)
    ) u_flag_ram (
        .i_clk  (i_clk),
        .i_we   (flag_we),
        .i_waddr(flag_waddr),
        .i_wdata(flag_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(flag_rdata)
    );

    lphs_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(r_idx),
        .i_wdata(r_key),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(key_rdata)
    );

    assign out_free    = !r_out_valid || i_out_ready;
    assign key_match   = flag_rdata.used && (key_rdata == r_key);
    assign next_idx    = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic finish;
        logic last;
        finish       = 1'b0;
        last         = (r_probe == LAST_IDX);
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_idx        = r_idx;
        n_probe      = r_probe;
        n_used_count = r_used_count;
        n_status     = r_status;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid && !i_out_ready;
        home_start   = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;
        flag_we      = 1'b0;
        flag_waddr   = r_idx;
        flag_wdata   = '0;
        key_we       = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                flag_we = 1'b1;
                n_idx   = next_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_operation;
                    n_key      = t_key'(i_key);
                    home_start = 1'b1;
                    n_state    = S_HOME;
                end
            end
            S_HOME: begin
                if (home_done) begin
                    if (r_op == OP_INSERT || r_op == OP_REMOVE || r_op == OP_FIND) begin
                        ram_re    = 1'b1;
                        ram_raddr = home_idx;
                        n_idx     = home_idx;
                        n_probe   = '0;
                        n_state   = S_PROBE;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_NOT_FOUND;
                        n_slot      = '0;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_PROBE: begin
                if (r_op == OP_INSERT) begin
                    if (!flag_rdata.used) begin
                        finish = 1'b1;
                        if (r_used_count < r_max_fill) begin
                            n_status = ST_INSERTED;
                            n_slot   = r_idx;
                        end else begin
                            n_status = ST_FULL;
                            n_slot   = '0;
                        end
                    end else if (key_match) begin
                        finish   = 1'b1;
                        n_status = flag_rdata.deleted ? ST_INSERTED : ST_PRESENT;
                        n_slot   = r_idx;
                    end else if (last) begin
                        finish   = 1'b1;
                        n_status = ST_FULL;
                        n_slot   = '0;
                    end
                end else begin
                    if (key_match && !flag_rdata.deleted) begin
                        finish   = 1'b1;
                        n_status = (r_op == OP_REMOVE) ? ST_REMOVED : ST_FOUND;
                        n_slot   = r_idx;
                    end else if (!flag_rdata.used || last) begin
                        finish   = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_slot   = '0;
                    end
                end

                if (finish) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                        if (r_op == OP_INSERT && !flag_rdata.used
                                && r_used_count < r_max_fill) begin
                            key_we       = 1'b1;
                            flag_we      = 1'b1;
                            flag_wdata   = '{used: 1'b1, deleted: 1'b0};
                            n_used_count = r_used_count + FILL_W'(1);
                        end else if (r_op == OP_INSERT && key_match
                                && flag_rdata.deleted) begin
                            flag_we    = 1'b1;
                            flag_wdata = '{used: 1'b1, deleted: 1'b0};
                        end else if (r_op == OP_REMOVE && key_match
                                && !flag_rdata.deleted) begin
                            flag_we    = 1'b1;
                            flag_wdata = '{used: 1'b1, deleted: 1'b1};
                        end
                    end else begin
                        n_status = r_status;
                        n_slot   = r_slot;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = next_idx;
                    n_idx     = next_idx;
                    n_probe   = r_probe + IDX_W'(1);
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_probe      <= '0;
            r_used_count <= '0;
            r_max_fill   <= MAX_FILL_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_probe      <= n_probe;
            r_used_count <= n_used_count;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_fill <= i_cfg_max_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = SLOT_W'(r_slot);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_used_count) <= TABLE_DEPTH)
        else $error("Occupied slot count exceeds the table depth.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_used_count != $past(r_used_count))
            |-> r_used_count == $past(r_used_count) + FILL_W'(1))
        else $error("Occupied slot count moved by other than one.");

    a_key_write_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> flag_we && flag_wdata.used && !flag_wdata.deleted
            && r_state == S_PROBE)
        else $error("Key written without marking its slot live.");

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL || o_status == ST_NOT_FOUND)
            |-> o_slot == '0)
        else $error("A miss or full result carries a nonzero slot.");

    a_no_write_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR && flag_we |-> out_free)
        else $error("Slot store updated while the result could not be taken.");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_linear_probe_hash_set.sv @@
// Self-checking testbench for the linear probing hash set: directed table, random traffic, full table.
`default_nettype none

module tb_linear_probe_hash_set;
    import lphs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = DEFAULT_TABLE_DEPTH;
    localparam int POOL_SIZE   = 40;
    localparam int RAND_PHASES = 4;
    localparam int PHASE_ITEMS = 90;
    localparam int LAST_ITEMS  = 30;
    localparam int MAX_SHOWN   = 10;

    localparam t_op OP_UNKNOWN = 2'd3;

    localparam int ZONE_BASE [4] = '{1020, 96, 511, 700};

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        t_op                 op;
        t_key                key;
        logic                typed;
        t_status             status;
        logic [SLOT_W-1:0]   slot;
        t_fill               fill;
    } t_row;

    typedef struct {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
    } t_answer;

    localparam t_row PLAN [25] = '{
        '{ROW_CFG, OP_FIND,    32'h0000_0000, 1'b0, ST_NOT_FOUND, 10'd0,    11'd1},
        '{ROW_REQ, OP_FIND,    32'h0000_0000, 1'b1, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_REMOVE,  32'h0000_0005, 1'b1, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_UNKNOWN, 32'h0000_0007, 1'b1, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'h7FFF_FFFF, 1'b1, ST_INSERTED,  10'd1023, 11'd0},
        '{ROW_REQ, OP_INSERT,  32'h0000_0001, 1'b1, ST_FULL,      10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'h7FFF_FFFF, 1'b1, ST_PRESENT,   10'd1023, 11'd0},
        '{ROW_REQ, OP_FIND,    32'h7FFF_FFFF, 1'b1, ST_FOUND,     10'd1023, 11'd0},
        '{ROW_REQ, OP_REMOVE,  32'h7FFF_FFFF, 1'b1, ST_REMOVED,   10'd1023, 11'd0},
        '{ROW_REQ, OP_FIND,    32'h7FFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'h7FFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_CFG, OP_FIND,    32'h0000_0000, 1'b0, ST_NOT_FOUND, 10'd0,    11'd1024},
        '{ROW_REQ, OP_INSERT,  32'h8000_0000, 1'b1, ST_INSERTED,  10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'hFFFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_REMOVE,  32'h7FFF_FFFF, 1'b1, ST_REMOVED,   10'd1023, 11'd0},
        '{ROW_REQ, OP_FIND,    32'hFFFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'h0000_03FF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_REMOVE,  32'hFFFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'hFFFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'hFFFF_FFFF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_FIND,    32'h0000_03FF, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_REMOVE,  32'h0000_0000, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_INSERT,  32'hAAAA_AAAA, 1'b0, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_FIND,    32'h5555_5555, 1'b1, ST_NOT_FOUND, 10'd0,    11'd0},
        '{ROW_REQ, OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 10'd0,    11'd0}
    };

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    t_op               i_operation    = OP_INSERT;
    t_key              i_key          = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    t_status           o_status;
    logic [SLOT_W-1:0] o_slot;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    t_fill             i_cfg_max_fill = MAX_FILL_RESET;

    t_key        tbl_key  [TABLE_SLOTS];
    bit          tbl_used [TABLE_SLOTS];
    bit          tbl_gone [TABLE_SLOTS];
    int unsigned fill_count = 0;
    int unsigned fill_limit = MAX_FILL_RESET;

    t_answer     answers_due [$];
    int          fault_count = 0;
    int          n_sent      = 0;
    int          n_results   = 0;
    int          n_cfg       = 0;
    int          status_tally [6] = '{0, 0, 0, 0, 0, 0};

    linear_probe_hash_set #(
        .TABLE_DEPTH(TABLE_SLOTS)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .i_key(i_key),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_slot(o_slot),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_max_fill(i_cfg_max_fill)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned home_slot(t_key key);
        int signed_key;
        int rem;
        signed_key = signed'(key);
        rem = signed_key % TABLE_SLOTS;
        if (rem < 0) begin
            rem += TABLE_SLOTS;
        end
        return rem;
    endfunction

    function automatic void apply_request(input t_op op, input t_key key,
                                          output t_status st, output logic [SLOT_W-1:0] sl);
        int unsigned idx;
        st  = ST_NOT_FOUND;
        sl  = '0;
        idx = home_slot(key);
        case (op)
            OP_INSERT: begin
                st = ST_FULL;
                for (int n = 0; n < TABLE_SLOTS; n++) begin
                    if (!tbl_used[idx]) begin
                        if (fill_count < fill_limit) begin
                            tbl_key[idx]  = key;
                            tbl_used[idx] = 1'b1;
                            tbl_gone[idx] = 1'b0;
                            fill_count++;
                            st = ST_INSERTED;
                            sl = SLOT_W'(idx);
                        end
                        break;
                    end
                    if (tbl_key[idx] == key) begin
                        st = tbl_gone[idx] ? ST_INSERTED : ST_PRESENT;
                        tbl_gone[idx] = 1'b0;
                        sl = SLOT_W'(idx);
                        break;
                    end
                    idx = (idx + 1) % TABLE_SLOTS;
                end
            end
            OP_REMOVE, OP_FIND: begin
                for (int n = 0; n < TABLE_SLOTS; n++) begin
                    if (!tbl_used[idx]) begin
                        break;
                    end
                    if (!tbl_gone[idx] && tbl_key[idx] == key) begin
                        if (op == OP_REMOVE) begin
                            tbl_gone[idx] = 1'b1;
                            st = ST_REMOVED;
                        end else begin
                            st = ST_FOUND;
                        end
                        sl = SLOT_W'(idx);
                        break;
                    end
                    idx = (idx + 1) % TABLE_SLOTS;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic t_op pick_op();
        int pick;
        pick = $urandom_range(99);
        return (pick < 40) ? OP_INSERT : (pick < 65) ? OP_REMOVE :
               (pick < 95) ? OP_FIND : OP_UNKNOWN;
    endfunction

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_SHOWN) begin
            $display("%s", msg);
        end
    endfunction

    task automatic send_item(t_op op, t_key key, logic typed, t_status st,
                             logic [SLOT_W-1:0] sl);
        t_status           p_st;
        logic [SLOT_W-1:0] p_sl;
        bit                calm;
        calm = (n_sent >= 400) && (n_sent < 560);
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        do @(posedge i_clk); while (!o_in_ready);
        apply_request(op, key, p_st, p_sl);
        if (typed) begin
            answers_due.push_back('{st, sl});
        end else begin
            answers_due.push_back('{p_st, p_sl});
        end
        n_sent++;
    endtask

    task automatic set_fill_limit(int unsigned value);
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_max_fill <= t_fill'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        fill_limit = value;
        n_cfg++;
    endtask

    always @(posedge i_clk) begin : check_result
        t_answer due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (o_status <= ST_FULL) begin
                status_tally[o_status]++;
            end
            if (answers_due.size() == 0) begin
                log_fault($sformatf("Unexpected result beat: status %0d slot %0d.",
                                    o_status, o_slot));
            end else begin
                due = answers_due.pop_front();
                if (due.status !== o_status || due.slot !== o_slot) begin
                    log_fault($sformatf(
                        "Result %0d mismatch: expected status %0d slot %0d, got status %0d slot %0d.",
                        n_results, due.status, due.slot, o_status, o_slot));
                end
            end
        end
    end

    initial begin : sink
        int seen;
        int hold;
        bit held;
        seen = 0;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                seen++;
            end
            if (!held && seen >= 130) begin
                held = 1'b1;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else if (seen >= 400 && seen < 560) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_key        pool [POOL_SIZE];
        t_key        raw;
        t_key        key;
        int unsigned home;
        int unsigned limit;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN[i]) begin
            if (PLAN[i].kind == ROW_CFG) begin
                set_fill_limit(PLAN[i].fill);
            end else begin
                send_item(PLAN[i].op, PLAN[i].key, PLAN[i].typed, PLAN[i].status,
                          PLAN[i].slot);
            end
        end

        // Keys crowd a few home zones so probe chains collide, one of them across the wrap.
        for (int k = 0; k < POOL_SIZE; k++) begin
            home    = (ZONE_BASE[$urandom_range(3)] + $urandom_range(7)) % TABLE_SLOTS;
            raw     = $urandom();
            pool[k] = (raw & ~t_key'(TABLE_SLOTS - 1)) | t_key'(home);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       limit = MAX_FILL_RESET;
                1:       limit = $urandom_range(1, TABLE_SLOTS);
                2:       limit = (fill_count + 3 > TABLE_SLOTS) ? TABLE_SLOTS : fill_count + 3;
                default: limit = $urandom_range(1, 96);
            endcase
            set_fill_limit(limit);
            repeat (PHASE_ITEMS) begin
                key = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)]
                                                : t_key'($urandom());
                send_item(pick_op(), key, 1'b0, ST_NOT_FOUND, '0);
            end
        end

        // Every free slot gets a key whose home is that slot, so the table ends up full.
        set_fill_limit(TABLE_SLOTS);
        for (int idx = 0; idx < TABLE_SLOTS; idx++) begin
            if (!tbl_used[idx]) begin
                raw = $urandom();
                key = (raw & ~t_key'(TABLE_SLOTS - 1)) | t_key'(idx);
                send_item(OP_INSERT, key, 1'b0, ST_NOT_FOUND, '0);
            end
        end

        repeat (LAST_ITEMS) begin
            key = ($urandom_range(1) == 1) ? tbl_key[$urandom_range(TABLE_SLOTS - 1)]
                                           : t_key'($urandom());
            send_item(pick_op(), key, 1'b0, ST_NOT_FOUND, '0);
        end

        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        $display("Run covered %0d requests, %0d results and %0d fill limit writes; %0d of %0d slots used.",
                 n_sent, n_results, n_cfg, fill_count, TABLE_SLOTS);
        $display("Statuses seen: inserted %0d, present %0d, removed %0d, absent %0d, found %0d, full %0d.",
                 status_tally[ST_INSERTED], status_tally[ST_PRESENT], status_tally[ST_REMOVED],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FOUND], status_tally[ST_FULL]);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/lphs_pkg.sv
design/lphs_ram.sv
design/lphs_home.sv
design/linear_probe_hash_set.sv
tb/sv/tb_linear_probe_hash_set.sv
